// ===== sv/q2yaw_pkg.sv =====
// Shared constants, widths and the arctangent table for the quaternion yaw core.
// No dependencies; every other file imports this package.
package q2yaw_pkg;

  localparam int COMP_W           = 16;  // quaternion component width
  localparam int ANGLE_W          = 16;  // output binary angle width
  localparam int ACC_W            = 33;  // angle accumulator, 2^31 units = pi
  localparam int ATAN_LEN         = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 14;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic signed [ACC_W-1:0] HALF_PI = 33'sh40000000;

  // atan(2^-i) in units where pi = 2^31
  localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // width of the sine / cosine terms for a given fraction width
  function automatic int term_width(int frac);
    int m;
    m = (2 * frac > 2 * COMP_W + 1) ? 2 * frac : 2 * COMP_W + 1;
    return m + 2;
  endfunction

  // CORDIC datapath width: terms plus headroom for sqrt(2) and gain 1.647
  function automatic int cordic_width(int frac);
    return term_width(frac) + 2;
  endfunction

  function automatic int step_count(int steps);
    return (steps > ATAN_LEN) ? ATAN_LEN : steps;
  endfunction

endpackage

// ===== sv/q2yaw_if.sv =====
// Valid/ready channel interfaces for the quaternion input and the yaw output.
// Depends on q2yaw_pkg.
interface q2yaw_quat_if import q2yaw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] quat_w;
  logic signed [COMP_W-1:0] quat_x;
  logic signed [COMP_W-1:0] quat_y;
  logic signed [COMP_W-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink (input valid, input quat_w, input quat_x, input quat_y,
                input quat_z, output ready);
endinterface

interface q2yaw_yaw_if import q2yaw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] yaw_angle;

  modport source (output valid, output yaw_angle, input ready);
  modport sink (input valid, input yaw_angle, output ready);
endinterface

// ===== sv/q2yaw_front.sv =====
// Front end: products, sine/cosine terms, zero detect and quadrant pre-rotation.
// Depends on q2yaw_pkg and q2yaw_quat_if; feeds q2yaw_queue.
module q2yaw_front import q2yaw_pkg::*; #(
  parameter int COMPONENT_FRACTION_BITS = FRAC_BITS_DEF,
  parameter int DW = 1 + ACC_W + 2 * cordic_width(COMPONENT_FRACTION_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  q2yaw_quat_if.sink    quat,
  input  logic          full,
  output logic          push,
  output logic [DW-1:0] push_data
);

  localparam int TW = term_width(COMPONENT_FRACTION_BITS);
  localparam int CW = cordic_width(COMPONENT_FRACTION_BITS);
  localparam int PW = 2 * COMP_W;
  localparam logic signed [TW-1:0] ONE = {{(TW-1){1'b0}}, 1'b1} << (2 * COMPONENT_FRACTION_BITS);

  typedef struct packed {
    logic                    zero;
    logic signed [ACC_W-1:0] acc;
    logic signed [CW-1:0]    y;
    logic signed [CW-1:0]    x;
  } vec_t;

  logic                 en;
  logic                 v1, v2, v3;
  logic signed [PW-1:0] p_wz, p_xy, p_yy, p_zz;
  logic signed [PW:0]   sum_s, sum_c;
  logic signed [TW-1:0] s_term, c_term;
  vec_t                 vec, vec_next;

  assign en = !v3 || !full;
  assign quat.ready = en && !rst;
  assign push = v3;
  assign push_data = vec;

  assign sum_s = (PW+1)'(p_wz) + (PW+1)'(p_xy);
  assign sum_c = (PW+1)'(p_yy) + (PW+1)'(p_zz);

  always_comb begin
    vec_next.zero = (s_term == '0) && (c_term == '0);
    vec_next.x    = CW'(c_term);
    vec_next.y    = CW'(s_term);
    vec_next.acc  = '0;
    if (c_term[TW-1]) begin
      if (!s_term[TW-1]) begin
        vec_next.x   = CW'(s_term);
        vec_next.y   = -CW'(c_term);
        vec_next.acc = HALF_PI;
      end else begin
        vec_next.x   = -CW'(s_term);
        vec_next.y   = CW'(c_term);
        vec_next.acc = -HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= quat.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wz   <= quat.quat_w * quat.quat_z;
      p_xy   <= quat.quat_x * quat.quat_y;
      p_yy   <= quat.quat_y * quat.quat_y;
      p_zz   <= quat.quat_z * quat.quat_z;
      s_term <= TW'(sum_s) <<< 1;
      c_term <= ONE - (TW'(sum_c) <<< 1);
      vec    <= vec_next;
    end
  end

endmodule

// ===== sv/q2yaw_queue.sv =====
// Short FIFO that decouples the front end from the CORDIC back end.
// Depends on q2yaw_pkg for the default depth.
module q2yaw_queue import q2yaw_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == NW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  ap_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(DEPTH))
    else $error("queue count above depth");

  ap_count_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

  ap_count_down: assert property (@(posedge clk) disable iff (rst)
    do_pop && !do_push |=> count == $past(count) - 1'b1)
    else $error("queue count missed a pop");

endmodule

// ===== sv/q2yaw_back.sv =====
// Back end: pipelined CORDIC vectoring, one step per stage, then angle rounding.
// Depends on q2yaw_pkg and q2yaw_yaw_if; drains q2yaw_queue.
module q2yaw_back import q2yaw_pkg::*; #(
  parameter int CORDIC_STEPS            = CORDIC_STEPS_DEF,
  parameter int COMPONENT_FRACTION_BITS = FRAC_BITS_DEF,
  parameter int DW = 1 + ACC_W + 2 * cordic_width(COMPONENT_FRACTION_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  output logic          pop,
  input  logic [DW-1:0] pop_data,
  q2yaw_yaw_if.source   yaw
);

  localparam int CW  = cordic_width(COMPONENT_FRACTION_BITS);
  localparam int NS  = step_count(CORDIC_STEPS);
  localparam int RSH = ACC_W - 1 - ANGLE_W;
  localparam logic signed [ACC_W-1:0] ROUND = {{(ACC_W-1){1'b0}}, 1'b1} << (RSH - 1);

  typedef struct packed {
    logic                    zero;
    logic signed [ACC_W-1:0] acc;
    logic signed [CW-1:0]    y;
    logic signed [CW-1:0]    x;
  } vec_t;

  logic                    en;
  vec_t                    head;
  logic                    vld  [NS+1];
  logic                    zero [NS+1];
  logic signed [CW-1:0]    x_r  [NS+1];
  logic signed [CW-1:0]    y_r  [NS+1];
  logic signed [ACC_W-1:0] acc_r [NS+1];
  logic signed [CW-1:0]    x_n  [NS];
  logic signed [CW-1:0]    y_n  [NS];
  logic signed [ACC_W-1:0] acc_n [NS];
  logic signed [ACC_W-1:0] rounded;
  logic                    angle_vld;
  logic signed [ANGLE_W-1:0] angle;

  assign en   = !angle_vld || yaw.ready;
  assign pop  = en;
  assign head = pop_data;

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam logic signed [ACC_W-1:0] ANG = ACC_W'(ATAN_TABLE[i]);
    always_comb begin
      if (!y_r[i][CW-1]) begin
        x_n[i]   = x_r[i] + (y_r[i] >>> i);
        y_n[i]   = y_r[i] - (x_r[i] >>> i);
        acc_n[i] = acc_r[i] + ANG;
      end else begin
        x_n[i]   = x_r[i] - (y_r[i] >>> i);
        y_n[i]   = y_r[i] + (x_r[i] >>> i);
        acc_n[i] = acc_r[i] - ANG;
      end
    end
  end

  assign rounded = acc_r[NS] + ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NS; i++) begin
        vld[i] <= 1'b0;
      end
      angle_vld <= 1'b0;
    end else if (en) begin
      vld[0] <= !empty;
      for (int i = 0; i < NS; i++) begin
        vld[i+1] <= vld[i];
      end
      angle_vld <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0]  <= head.zero;
      x_r[0]   <= head.x;
      y_r[0]   <= head.y;
      acc_r[0] <= head.acc;
      for (int i = 0; i < NS; i++) begin
        zero[i+1]  <= zero[i];
        x_r[i+1]   <= x_n[i];
        y_r[i+1]   <= y_n[i];
        acc_r[i+1] <= acc_n[i];
      end
      angle <= zero[NS] ? '0 : rounded[RSH+ANGLE_W-1:RSH];
    end
  end

  assign yaw.valid     = angle_vld;
  assign yaw.yaw_angle = angle;

  // pre-rotation leaves x in the right half plane, and vectoring never lowers x
  ap_head_right_half: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> !x_r[0][CW-1])
    else $error("pre-rotated x is negative");

  ap_last_right_half: assert property (@(posedge clk) disable iff (rst)
    vld[NS] |-> !x_r[NS][CW-1])
    else $error("CORDIC x overflowed or went negative");

  ap_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld[NS] == $past(vld[NS]) && vld[0] == $past(vld[0]))
    else $error("pipeline moved while output stalled");

endmodule

// ===== sv/quaternion_to_yaw_angle_core.sv =====
// Quaternion to yaw angle: heading atan2(2(wz+xy), 1-2(y^2+z^2)) as a 16-bit binary
// angle (32768 = pi, +pi wraps to -32768; a zero vector gives 0). One quaternion is
// accepted per clock and one angle leaves per clock under a free-running output. The
// path runs through three front stages (products, terms, pre-rotation), a two-entry queue,
// a CORDIC input register, one register per CORDIC step and an output register.
// Depends on q2yaw_pkg, q2yaw_if, q2yaw_front, q2yaw_queue and q2yaw_back.
module quaternion_to_yaw_angle_core import q2yaw_pkg::*; #(
  parameter int CORDIC_STEPS            = CORDIC_STEPS_DEF,
  parameter int COMPONENT_FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  q2yaw_quat_if.sink   quat,
  q2yaw_yaw_if.source  yaw
);

  localparam int DW = 1 + ACC_W + 2 * cordic_width(COMPONENT_FRACTION_BITS);

  logic          push, full, pop, empty;
  logic [DW-1:0] push_data, pop_data;

  q2yaw_front #(
    .COMPONENT_FRACTION_BITS(COMPONENT_FRACTION_BITS),
    .DW(DW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .quat(quat),
    .full(full),
    .push(push),
    .push_data(push_data)
  );

  q2yaw_queue #(
    .DW(DW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(full),
    .pop(pop),
    .pop_data(pop_data),
    .empty(empty)
  );

  q2yaw_back #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .COMPONENT_FRACTION_BITS(COMPONENT_FRACTION_BITS),
    .DW(DW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .empty(empty),
    .pop(pop),
    .pop_data(pop_data),
    .yaw(yaw)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for quaternion_to_yaw_angle_core: drives quaternions over the
// valid/ready channel and compares each yaw angle against a bit-true CORDIC predictor.
// Depends on q2yaw_pkg, q2yaw_if and the core RTL.
module tb import q2yaw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS       = CORDIC_STEPS_DEF;
  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 1000;  // cycles with no transaction on either side
  localparam int DRAIN_WAIT  = STEPS + 12;

  typedef logic signed [COMP_W-1:0]  comp_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef struct {
    comp_t  w;
    comp_t  x;
    comp_t  y;
    comp_t  z;
    angle_t yaw;
  } heading_t;

  logic clk;
  logic rst;

  q2yaw_quat_if quat_bus ();
  q2yaw_yaw_if  yaw_bus ();

  quaternion_to_yaw_angle_core #(
    .CORDIC_STEPS            (STEPS),
    .COMPONENT_FRACTION_BITS (FRAC)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .quat (quat_bus),
    .yaw  (yaw_bus)
  );

  heading_t pending_yaws[$];
  int       err_count;
  int       quats_sent;
  int       yaws_checked;
  int       idle_cycles;
  bit       src_gaps;
  bit       sink_gaps;
  int       ready_hold;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // atan2(2(wz+xy), 1-2(y^2+z^2)) with quadrant pre-rotation and CORDIC vectoring
  function automatic angle_t predict_yaw(input comp_t w, input comp_t qx, input comp_t qy,
                                         input comp_t qz);
    longint sin_t;
    longint cos_t;
    longint vx;
    longint vy;
    longint dx;
    longint dy;
    longint ang;
    longint rounded;
    int     i;
    sin_t = 2 * (longint'(w) * longint'(qz) + longint'(qx) * longint'(qy));
    cos_t = (longint'(1) << (2 * FRAC)) -
            2 * (longint'(qy) * longint'(qy) + longint'(qz) * longint'(qz));
    if (sin_t == 0 && cos_t == 0) return '0;
    vx  = cos_t;
    vy  = sin_t;
    ang = 0;
    if (cos_t < 0) begin
      if (sin_t >= 0) begin
        vx  = sin_t;
        vy  = -cos_t;
        ang = longint'(HALF_PI);
      end else begin
        vx  = -sin_t;
        vy  = cos_t;
        ang = -longint'(HALF_PI);
      end
    end
    for (i = 0; i < STEPS && i < ATAN_LEN; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx  = vx + dx;
        vy  = vy - dy;
        ang = ang + longint'(ATAN_TABLE[i]);
      end else begin
        vx  = vx - dx;
        vy  = vy + dy;
        ang = ang - longint'(ATAN_TABLE[i]);
      end
    end
    rounded = (ang + 32768) >>> 16;
    return rounded[ANGLE_W-1:0];
  endfunction

  task automatic send_quat(input comp_t w, input comp_t x, input comp_t y, input comp_t z);
    heading_t h;
    if (src_gaps && $urandom_range(3) == 0) begin
      quat_bus.valid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(negedge clk);
    end
    quat_bus.valid  <= 1'b1;
    quat_bus.quat_w <= w;
    quat_bus.quat_x <= x;
    quat_bus.quat_y <= y;
    quat_bus.quat_z <= z;
    do @(posedge clk); while (!quat_bus.ready);
    h.w   = w;
    h.x   = x;
    h.y   = y;
    h.z   = z;
    h.yaw = predict_yaw(w, x, y, z);
    pending_yaws.push_back(h);
    quats_sent++;
    @(negedge clk);
  endtask

  function automatic comp_t unit_comp();
    return comp_t'(int'($urandom_range(32768)) - 16384);
  endfunction

  // axes, quadrant boundaries, zero vectors, +pi wrap and full-scale components
  task automatic test_directed();
    int dir_set [20][4] = '{
      '{16384, 0, 0, 0},           '{-16384, 0, 0, 0},
      '{0, 0, 0, 16384},           '{0, 0, 0, -16384},
      '{11585, 0, 0, 11585},       '{11585, 0, 0, -11585},
      '{0, 0, 0, 0},               '{0, 0, 8192, 8192},
      '{77, 77, 8192, -8192},      '{16384, 0, 8192, 8192},
      '{-16384, 0, 8192, 8192},    '{-8000, 0, 0, 14000},
      '{8000, 0, 0, 14000},        '{0, 16384, 16384, 0},
      '{32767, 32767, 32767, 32767},
      '{-32768, -32768, -32768, -32768},
      '{32767, -32768, 32767, -32768},
      '{-32768, 32767, -32768, 32767},
      '{16384, -16384, 16384, -16384},
      '{1, -1, -1, 1}
    };
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    foreach (dir_set[k])
      send_quat(comp_t'(dir_set[k][0]), comp_t'(dir_set[k][1]),
                comp_t'(dir_set[k][2]), comp_t'(dir_set[k][3]));
  endtask

  task automatic test_random_unit_range(input int count);
    repeat (count) send_quat(unit_comp(), unit_comp(), unit_comp(), unit_comp());
  endtask

  task automatic test_random_full_range(input int count);
    repeat (count)
      send_quat(comp_t'($urandom), comp_t'($urandom), comp_t'($urandom), comp_t'($urandom));
  endtask

  // y^2 + z^2 near 2^27 and wz + xy near 0: both terms small, any quadrant
  task automatic test_near_zero_vector(input int count);
    int    sy;
    int    sz;
    comp_t qy;
    comp_t qz;
    comp_t qx;
    repeat (count) begin
      sy = $urandom_range(1) ? 1 : -1;
      sz = $urandom_range(1) ? 1 : -1;
      qy = comp_t'(sy * (8192 + int'($urandom_range(6)) - 3));
      qz = comp_t'(sz * (8192 + int'($urandom_range(6)) - 3));
      qx = comp_t'(int'($urandom_range(400)) - 200);
      send_quat(comp_t'(-sy * sz * int'(qx) + int'($urandom_range(4)) - 2), qx, qy, qz);
    end
  endtask

  // output held off long enough to fill the pipeline and back up the input
  task automatic test_output_backpressure(input int count);
    src_gaps   = 1'b0;
    ready_hold = 80;
    test_random_unit_range(count);
    src_gaps = 1'b1;
  endtask

  task automatic test_full_rate_stream(input int count);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    test_random_full_range(count / 2);
    test_random_unit_range(count - count / 2);
  endtask

  // output ready: random stalls, one long hold-off on request, or always high
  initial begin : yaw_ready_ctl
    int n;
    yaw_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (ready_hold > 0) begin
        n          = ready_hold;
        ready_hold = 0;
        yaw_bus.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else if (sink_gaps && $urandom_range(3) == 0) begin
        yaw_bus.ready <= 1'b0;
        repeat ($urandom_range(9, 1)) @(negedge clk);
      end else begin
        yaw_bus.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    heading_t h;
    if (!rst && yaw_bus.valid && yaw_bus.ready) begin
      if (pending_yaws.size() == 0) begin
        $display("%0t: unexpected yaw transaction: expected none, actual %0d",
                 $time, yaw_bus.yaw_angle);
        err_count++;
      end else begin
        h = pending_yaws.pop_front();
        yaws_checked++;
        if (yaw_bus.yaw_angle !== h.yaw) begin
          $display("%0t: yaw_angle mismatch for q=(%0d,%0d,%0d,%0d): expected %0d, actual %0d",
                   $time, h.w, h.x, h.y, h.z, h.yaw, yaw_bus.yaw_angle);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (quat_bus.valid && quat_bus.ready) || (yaw_bus.valid && yaw_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_yaws.size());
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    quat_bus.valid  = 1'b0;
    quat_bus.quat_w = '0;
    quat_bus.quat_x = '0;
    quat_bus.quat_y = '0;
    quat_bus.quat_z = '0;
    err_count       = 0;
    quats_sent      = 0;
    yaws_checked    = 0;
    idle_cycles     = 0;
    src_gaps        = 1'b1;
    sink_gaps       = 1'b1;
    ready_hold      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_unit_range(600);
    test_random_full_range(500);
    test_near_zero_vector(200);
    test_output_backpressure(80);
    test_full_rate_stream(250);

    quat_bus.valid <= 1'b0;
    while (pending_yaws.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d quaternions: axes, quadrant edges, zero vectors, full-scale,",
             quats_sent);
    $display("stalls and a long output hold-off; %0d angles checked, %0d errors",
             yaws_checked, err_count);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/q2yaw_pkg.sv
sv/q2yaw_if.sv
sv/q2yaw_front.sv
sv/q2yaw_queue.sv
sv/q2yaw_back.sv
sv/quaternion_to_yaw_angle_core.sv
sim/tb.sv
